>>> src/strrot_pkg.sv
// Shared types and constants for the string rotation checker.
// Used by strrot_ctrl, strrot_dp and string_rotation_checker; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package strrot_pkg;

  localparam int MAX_LEN = 128;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 2);
  localparam int OFF_W   = 7;

  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NOT_ROT  = 2'd1,
    ST_LEN_DIFF = 2'd2,
    ST_TOO_LONG = 2'd3
  } res_status_t;

  typedef enum logic {
    CMD_FIRST  = 1'b0,
    CMD_SECOND = 1'b1
  } load_cmd_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_READ,
    S_COMP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] rotation_offset;
  } out_beat_t;

  typedef struct packed {
    logic        load;
    logic        set_code;
    res_status_t code;
    logic        search_init;
    logic        step;
    logic        post;
  } strrot_cmd_t;

  typedef struct packed {
    logic ov;
    logic len_eq;
    logic match;
    logic j_last;
    logic k_last;
    logic out_free;
  } strrot_stat_t;

endpackage

`default_nettype wire

>>> src/strrot_ctrl.sv
// Controller state machine for the string rotation checker.
// Depends on strrot_pkg; drives commands into strrot_dp and reads its status.
`timescale 1ns / 1ps
`default_nettype none

module strrot_ctrl
  import strrot_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  input  wire logic         in_command,
  input  wire logic         in_last,
  output logic              in_ready,
  input  wire strrot_stat_t stat,
  output strrot_cmd_t       cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.code        = ST_FOUND;
    in_ready        = 1'b0;
    case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_command == CMD_SECOND && in_last) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.ov) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_TOO_LONG;
          state_next   = S_DONE;
        end else if (!stat.len_eq) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_LEN_DIFF;
          state_next   = S_DONE;
        end else begin
          cmd.search_init = 1'b1;
          state_next      = S_READ;
        end
      end
      S_READ: begin
        state_next = S_COMP;
      end
      S_COMP: begin
        if (stat.match && stat.j_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_FOUND;
          state_next   = S_DONE;
        end else if (!stat.match && stat.k_last) begin
          cmd.set_code = 1'b1;
          cmd.code     = ST_NOT_ROT;
          state_next   = S_DONE;
        end else begin
          cmd.step   = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/strrot_dp.sv
// Datapath for the string rotation checker: both character stores, counts,
// search indexes and the result register. Depends on strrot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module strrot_dp
  import strrot_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire in_beat_t    in_data,
  input  wire strrot_cmd_t cmd,
  output strrot_stat_t     stat,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_beat_t        out_data
);

  logic [7:0] first_mem  [MAX_LEN];
  logic [7:0] second_mem [MAX_LEN];

  logic [CNT_W-1:0] first_count, second_count;
  logic             overflow_seen, first_closed;
  logic [IDX_W-1:0] k, j, p;
  logic [7:0]       rd_first, rd_second;
  res_status_t      result_code;
  logic [OFF_W-1:0] result_offset;

  logic [CNT_W-1:0] fc_eff, sc_eff;
  logic             ov_eff;
  logic             wr_first, wr_second;
  logic [CNT_W-1:0] wr_count;
  logic [CNT_W-1:0] p_inc, k_inc;

  always_comb begin
    fc_eff    = first_count;
    sc_eff    = second_count;
    ov_eff    = overflow_seen;
    if (in_data.command == CMD_FIRST && first_closed) begin
      fc_eff = '0;
      sc_eff = '0;
      ov_eff = 1'b0;
    end
    wr_count  = (in_data.command == CMD_FIRST) ? fc_eff : sc_eff;
    wr_first  = cmd.load && in_data.command == CMD_FIRST &&
                fc_eff < CNT_W'(MAX_LEN);
    wr_second = cmd.load && in_data.command == CMD_SECOND &&
                sc_eff < CNT_W'(MAX_LEN);
    p_inc     = CNT_W'(p) + CNT_W'(1);
    k_inc     = CNT_W'(k) + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[wr_count[IDX_W-1:0]] <= in_data.char_code;
    end
    if (wr_second) begin
      second_mem[wr_count[IDX_W-1:0]] <= in_data.char_code;
    end
    rd_first  <= first_mem[p];
    rd_second <= second_mem[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_seen <= 1'b0;
      first_closed  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (in_data.command == CMD_FIRST) begin
          first_closed <= in_data.last_char;
          second_count <= sc_eff;
          if (fc_eff < CNT_W'(MAX_LEN + 1)) begin
            first_count <= fc_eff + CNT_W'(1);
          end else begin
            first_count <= fc_eff;
          end
          overflow_seen <= ov_eff || !(fc_eff < CNT_W'(MAX_LEN));
        end else begin
          if (second_count < CNT_W'(MAX_LEN + 1)) begin
            second_count <= second_count + CNT_W'(1);
          end
          if (!(second_count < CNT_W'(MAX_LEN))) begin
            overflow_seen <= 1'b1;
          end
        end
      end
      if (cmd.post) begin
        first_count   <= '0;
        second_count  <= '0;
        overflow_seen <= 1'b0;
        first_closed  <= 1'b0;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      k <= '0;
      j <= '0;
      p <= '0;
    end else if (cmd.step) begin
      if (stat.match) begin
        j <= j + IDX_W'(1);
        p <= (p_inc == first_count) ? '0 : p_inc[IDX_W-1:0];
      end else begin
        k <= k_inc[IDX_W-1:0];
        j <= '0;
        p <= k_inc[IDX_W-1:0];
      end
    end
    if (cmd.set_code) begin
      result_code   <= cmd.code;
      result_offset <= (cmd.code == ST_FOUND) ? OFF_W'(k) : '0;
    end
    if (cmd.post) begin
      out_data.status          <= result_code;
      out_data.rotation_offset <= result_offset;
    end
  end

  always_comb begin
    stat.ov       = overflow_seen;
    stat.len_eq   = first_count == second_count;
    stat.match    = rd_first == rd_second;
    stat.j_last   = (CNT_W'(j) + CNT_W'(1)) == first_count;
    stat.k_last   = k_inc == first_count;
    stat.out_free = !out_valid || out_ready;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    cmd.post |-> (!out_valid || out_ready))
    else $error("result register overwritten while full");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_FOUND |-> out_data.rotation_offset == '0)
    else $error("nonzero offset without a rotation");
  assert property (@(posedge clk) disable iff (rst)
    first_count <= CNT_W'(MAX_LEN + 1) && second_count <= CNT_W'(MAX_LEN + 1))
    else $error("count beyond saturation");
  assert property (@(posedge clk) disable iff (rst)
    cmd.post |=> first_count == '0 && second_count == '0 && !overflow_seen)
    else $error("pair state not cleared after result");
`endif

endmodule

`default_nettype wire

>>> src/string_rotation_checker.sv
// String rotation checker: loads two byte strings one beat per cycle, then
// reports whether the second is a left rotation of the first and the smallest
// offset. Beats tagged command 0 fill the first store, command 1 the second;
// last_char ends a string, and the second string's last beat starts the check.
// The check first tests length and overflow, then runs the character compares,
// each a registered read of both stores followed by a compare; each store has
// a single read port. Strings of up to 128 bytes are held. No input is taken
// while a check runs or while its result waits for the receiver.
// Depends on strrot_pkg, strrot_ctrl and strrot_dp.
`timescale 1ns / 1ps
`default_nettype none

module string_rotation_checker
  import strrot_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_beat_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_beat_t     out_data
);

  strrot_cmd_t  cmd;
  strrot_stat_t stat;

  strrot_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_last    (in_data.last_char),
    .in_ready   (in_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  strrot_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for string_rotation_checker: drives string pairs through the input
// beat channel and checks every result against a predictor of the rotation search.
// Depends on strrot_pkg and the string_rotation_checker RTL.
`timescale 1ns / 1ps

module tb_top
  import strrot_pkg::*;
;

  localparam int CLK_PERIOD   = 20;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_BEATS = 800;
  localparam int TAIL_CYCLES  = 200;
  localparam int MAX_REPORTS  = 50;

  typedef logic [7:0] chars_t[$];

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE
  } ready_mode_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  // Predictor state
  logic [7:0]  first_chars[MAX_LEN];
  logic [7:0]  second_chars[MAX_LEN];
  int unsigned first_len    = 0;
  int unsigned second_len   = 0;
  bit          len_overflow = 1'b0;
  bit          first_done   = 1'b0;
  out_beat_t   rotation_results_q[$];

  int unsigned     err_count   = 0;
  int unsigned     beat_count  = 0;
  int unsigned     burst_left  = 0;
  longint unsigned cycle_count = 0;
  ready_mode_t     ready_mode  = RDY_ALWAYS;
  int unsigned     ready_hold  = 0;

  string_rotation_checker u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver stalls: switch between stall patterns after a random hold
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
      ready_hold <= $urandom_range(4, 64);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      RDY_ALWAYS: out_ready <= 1'b1;
      RDY_RANDOM: out_ready <= 1'($urandom_range(0, 1));
      default:    out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  function automatic void clear_pair_state();
    first_len    = 0;
    second_len   = 0;
    len_overflow = 1'b0;
    first_done   = 1'b0;
  endfunction

  function automatic int smallest_rotation(int unsigned n);
    bit ok;
    for (int unsigned k = 0; k < n; k++) begin
      ok = 1'b1;
      for (int unsigned j = 0; j < n && ok; j++) begin
        if (first_chars[(k + j) % n] != second_chars[j]) ok = 1'b0;
      end
      if (ok) return int'(k);
    end
    return -1;
  endfunction

  function automatic void predict_rotation(in_beat_t b);
    out_beat_t res;
    int        k;
    if (b.command == CMD_FIRST) begin
      if (first_done) clear_pair_state();
      if (first_len < MAX_LEN) begin
        first_chars[first_len] = b.char_code;
        first_len++;
      end else begin
        len_overflow = 1'b1;
        if (first_len < MAX_LEN + 1) first_len++;
      end
      if (b.last_char) first_done = 1'b1;
    end else begin
      if (second_len < MAX_LEN) begin
        second_chars[second_len] = b.char_code;
        second_len++;
      end else begin
        len_overflow = 1'b1;
        if (second_len < MAX_LEN + 1) second_len++;
      end
      if (b.last_char) begin
        res = '0;
        if (len_overflow) begin
          res.status = ST_TOO_LONG;
        end else if (first_len != second_len) begin
          res.status = ST_LEN_DIFF;
        end else begin
          k = smallest_rotation(first_len);
          if (k >= 0) begin
            res.status          = ST_FOUND;
            res.rotation_offset = k[OFF_W-1:0];
          end else begin
            res.status = ST_NOT_ROT;
          end
        end
        rotation_results_q.push_back(res);
        clear_pair_state();
      end
    end
  endfunction

  task automatic report_mismatch(string msg);
    if (err_count < MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_result(out_beat_t got);
    out_beat_t want;
    if (rotation_results_q.size() == 0) begin
      report_mismatch($sformatf("result with none pending: status %0d offset %0d",
                                got.status, got.rotation_offset));
    end else begin
      want = rotation_results_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.rotation_offset !== want.rotation_offset)
        report_mismatch($sformatf("rotation_offset %0d, expected %0d",
                                  got.rotation_offset, want.rotation_offset));
    end
  endtask

  // Sample mid-cycle: the beat is taken at the next rising edge
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  task automatic send_beat(load_cmd_t cmd, logic [7:0] code, bit last);
    in_beat_t b;
    int       gap;
    bit       rdy;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    b.command   = cmd;
    b.char_code = code;
    b.last_char = last;
    in_valid <= 1'b1;
    in_data  <= b;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    predict_rotation(b);
    beat_count++;
  endtask

  task automatic send_chars(load_cmd_t cmd, chars_t s, bit close);
    for (int i = 0; i < s.size(); i++) send_beat(cmd, s[i], close && (i == s.size() - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rotation_results_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic chars_t rand_chars(int unsigned len);
    chars_t     s;
    int         pick;
    logic [7:0] a;
    logic [7:0] c;
    pick = $urandom_range(0, 9);
    a    = 8'($urandom_range(0, 255));
    c    = 8'($urandom_range(0, 255));
    for (int unsigned i = 0; i < len; i++) begin
      if (pick < 5)      s.push_back(8'($urandom_range(0, 255)));
      else if (pick < 9) s.push_back($urandom_range(0, 1) ? a : c);
      else               s.push_back(a);
    end
    return s;
  endfunction

  function automatic chars_t rotate_left(chars_t s, int unsigned k);
    chars_t r;
    for (int unsigned i = 0; i < s.size(); i++) r.push_back(s[(i + k) % s.size()]);
    return r;
  endfunction

  function automatic int unsigned pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 8);
    if (r < 97) return $urandom_range(9, 32);
    return $urandom_range(33, MAX_LEN);
  endfunction

  task automatic send_rotation_pair(int unsigned len);
    chars_t a;
    a = rand_chars(len);
    send_chars(CMD_FIRST, a, 1'b1);
    send_chars(CMD_SECOND, rotate_left(a, $urandom_range(0, len - 1)), 1'b1);
  endtask

  task automatic test_directed();
    // byte extremes, offset one
    send_chars(CMD_FIRST, '{8'h00, 8'hFF}, 1'b1);
    send_chars(CMD_SECOND, '{8'hFF, 8'h00}, 1'b1);
    // single character
    send_chars(CMD_FIRST, '{8'h5A}, 1'b1);
    send_chars(CMD_SECOND, '{8'h5A}, 1'b1);
    // not a rotation
    send_chars(CMD_FIRST, '{8'h01, 8'h02}, 1'b1);
    send_chars(CMD_SECOND, '{8'h01, 8'h01}, 1'b1);
    // lengths differ
    send_chars(CMD_FIRST, '{8'h11, 8'h22}, 1'b1);
    send_chars(CMD_SECOND, '{8'h11}, 1'b1);
    // second string with no first string
    send_chars(CMD_SECOND, '{8'h33}, 1'b1);
    // second string before the first is closed
    send_chars(CMD_FIRST, '{8'hAA, 8'hBB}, 1'b0);
    send_chars(CMD_SECOND, '{8'hBB, 8'hAA}, 1'b1);
    // new first string after a closed one
    send_chars(CMD_FIRST, '{8'h01}, 1'b1);
    send_chars(CMD_FIRST, '{8'h07, 8'h08}, 1'b1);
    send_chars(CMD_SECOND, '{8'h08, 8'h07}, 1'b1);
    wait_drained();
  endtask

  task automatic test_long_strings();
    chars_t a;
    chars_t b;
    // full-size rotation
    a = {};
    for (int i = 0; i < MAX_LEN; i++) a.push_back(8'($urandom_range(0, 255)));
    send_chars(CMD_FIRST, a, 1'b1);
    send_chars(CMD_SECOND, rotate_left(a, $urandom_range(1, MAX_LEN - 1)), 1'b1);
    // full-size near match: every offset runs to the end
    a = {};
    for (int i = 0; i < MAX_LEN; i++) a.push_back(8'h41);
    b = a;
    b[MAX_LEN - 1] = 8'h42;
    send_chars(CMD_FIRST, a, 1'b1);
    send_chars(CMD_SECOND, b, 1'b1);
    // overflow cases, including overflow with unequal lengths
    send_chars(CMD_FIRST, rand_chars(MAX_LEN + 1), 1'b1);
    send_chars(CMD_SECOND, rand_chars(MAX_LEN + 1), 1'b1);
    send_chars(CMD_FIRST, rand_chars(MAX_LEN + 12), 1'b1);
    send_chars(CMD_SECOND, rand_chars(3), 1'b1);
    send_chars(CMD_FIRST, rand_chars(MAX_LEN), 1'b1);
    send_chars(CMD_SECOND, rand_chars(MAX_LEN + 1), 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int unsigned start;
    int unsigned len;
    int unsigned len2;
    int          kind;
    chars_t      a;
    chars_t      b;
    start = beat_count;
    while (beat_count - start < RANDOM_BEATS) begin
      kind = $urandom_range(0, 99);
      len  = pick_len();
      if (kind < 55) begin
        send_rotation_pair(len);
      end else if (kind < 70) begin
        a = rand_chars(len);
        b = rotate_left(a, $urandom_range(0, len - 1));
        b[$urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
        send_chars(CMD_FIRST, a, 1'b1);
        send_chars(CMD_SECOND, b, 1'b1);
      end else if (kind < 78) begin
        len2 = pick_len();
        if (len2 == len) len2 = len + 1;
        send_chars(CMD_FIRST, rand_chars(len), 1'b1);
        send_chars(CMD_SECOND, rand_chars(len2), 1'b1);
      end else if (kind < 83) begin
        len2 = MAX_LEN + $urandom_range(1, 4);
        if ($urandom_range(0, 1)) begin
          send_chars(CMD_FIRST, rand_chars(len2), 1'b1);
          send_chars(CMD_SECOND, rand_chars(len), 1'b1);
        end else begin
          send_chars(CMD_FIRST, rand_chars(len), 1'b1);
          send_chars(CMD_SECOND, rand_chars(len2), 1'b1);
        end
      end else if (kind < 88) begin
        a = rand_chars(len);
        send_chars(CMD_FIRST, a, 1'b0);
        send_chars(CMD_SECOND, rotate_left(a, $urandom_range(0, len - 1)), 1'b1);
      end else if (kind < 93) begin
        send_chars(CMD_FIRST, rand_chars(pick_len()), 1'b1);
        send_rotation_pair(len);
      end else if (kind < 97) begin
        send_chars(CMD_SECOND, rand_chars(len), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_beat(load_cmd_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                    $urandom_range(0, 2) == 0);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_strings();
    test_random();
    if (err_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
